// ----- hdl/tcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // Width of every input coordinate and of the centre and radius results.
    localparam int COORD_WIDTH = 24;
    localparam int W   = COORD_WIDTH;
    // Vertex differences, squared sums and the doubled determinant.
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int SQW = 2 * DW + 2;
    // Chunk width used to split wide products into small multipliers.
    localparam int CH  = 26;
    // Numerators of the centre offset and the exact inside term.
    localparam int NW  = DW + SQW + 1;
    localparam int EW  = NW + DW + 3;
    // Divider: quotient bits and remainder width.
    localparam int QB  = W + 2;
    localparam int RW  = NW + 2;
    // Centre sum before clamping, and the squared radius.
    localparam int VW  = W + 4;
    localparam int SRW = 2 * W;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_COLL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Side data that travels along the divider cells.
    typedef struct packed {
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic         neg_x;
        logic         neg_y;
        logic         big_x;
        logic         big_y;
        logic         in_circle;
        logic         coll;
    } t_div_side;

    typedef struct packed {
        logic          vld;
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [RW-1:0] dv;
        logic [QB-1:0] q_x;
        logic [QB-1:0] q_y;
        t_div_side     side;
    } t_div_beat;

    // Side data that travels along the square root cells.
    typedef struct packed {
        logic [W-1:0] cen_x;
        logic [W-1:0] cen_y;
        logic         in_circle;
        logic         coll;
        logic         sat;
        logic         rsat;
    } t_sqrt_side;

    typedef struct packed {
        logic           vld;
        logic [SRW-1:0] x;
        logic [SRW:0]   res;
        logic [SRW:0]   pos;
        t_sqrt_side     side;
    } t_sqrt_beat;

endpackage

`default_nettype wire

// ----- hdl/tcc_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcc_pkg::t_div_beat  i_beat,
    output tcc_pkg::t_div_beat  o_beat
);
    import tcc_pkg::*;

    t_div_beat n_beat;
    t_div_beat r_beat;

    // One restoring step for both quotients; the divisor moves one place right.
    always_comb begin
        n_beat = i_beat;
        if (i_beat.rem_x >= i_beat.dv) begin
            n_beat.rem_x = i_beat.rem_x - i_beat.dv;
            n_beat.q_x   = {i_beat.q_x[QB-2:0], 1'b1};
        end else begin
            n_beat.q_x   = {i_beat.q_x[QB-2:0], 1'b0};
        end
        if (i_beat.rem_y >= i_beat.dv) begin
            n_beat.rem_y = i_beat.rem_y - i_beat.dv;
            n_beat.q_y   = {i_beat.q_y[QB-2:0], 1'b1};
        end else begin
            n_beat.q_y   = {i_beat.q_y[QB-2:0], 1'b0};
        end
        n_beat.dv = i_beat.dv >> 1;
        // Synchronous reset clears only the valid flag.
        n_beat.vld = i_beat.vld & i_rst_n;
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ----- hdl/tcc_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcc_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcc_pkg::t_sqrt_beat i_beat,
    output tcc_pkg::t_sqrt_beat o_beat
);
    import tcc_pkg::*;

    t_sqrt_beat   n_beat;
    t_sqrt_beat   r_beat;
    logic [SRW:0] w_trial;

    // One digit of the bitwise square root.
    always_comb begin
        n_beat  = i_beat;
        w_trial = i_beat.res + i_beat.pos;
        if ({1'b0, i_beat.x} >= w_trial) begin
            n_beat.x   = i_beat.x - w_trial[SRW-1:0];
            n_beat.res = (i_beat.res >> 1) + i_beat.pos;
        end else begin
            n_beat.res = i_beat.res >> 1;
        end
        n_beat.pos = i_beat.pos >> 2;
        // Synchronous reset clears only the valid flag.
        n_beat.vld = i_beat.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ----- hdl/triangle_circumcircle_point_test.sv -----
// Throughput: one beat per cycle; busy stays low, so start may be high every cycle.
// A beat passes the 12 product stages, 26 divider cells, 3 radius stages,
// 24 square root cells and the output register.
// Reset (synchronous, active low) clears all valid flags; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module triangle_circumcircle_point_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_a_x,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_a_y,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_b_x,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_b_y,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_c_x,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_vertex_c_y,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_query_x,
    input  logic signed [tcc_pkg::COORD_WIDTH-1:0] i_query_y,
    output logic                                   o_done,
    output logic signed [tcc_pkg::COORD_WIDTH-1:0] o_centre_x,
    output logic signed [tcc_pkg::COORD_WIDTH-1:0] o_centre_y,
    output logic        [tcc_pkg::COORD_WIDTH-1:0] o_circle_radius,
    output logic                                   o_point_inside,
    output logic        [1:0]                      o_result_status
);
    import tcc_pkg::*;

    localparam logic signed [VW-1:0] CEN_MAX = VW'($signed({1'b0, {(W-1){1'b1}}}));
    localparam logic signed [VW-1:0] CEN_MIN = VW'($signed({1'b1, {(W-1){1'b0}}}));

    logic        w_acc;
    logic [10:0] r_vld;

    // The pipeline never stalls, so every start is taken.
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], w_acc};
        end
    end

    // Stage 1: differences relative to the first vertex.
    logic signed [W-1:0]  r1_ax, r1_ay;
    logic signed [DW-1:0] r1_bx, r1_by, r1_cx, r1_cy, r1_qx, r1_qy;
    // Stage 2: squares and cross products.
    logic signed [W-1:0]  r2_ax, r2_ay;
    logic signed [DW-1:0] r2_bx, r2_by, r2_cx, r2_cy, r2_qx, r2_qy;
    logic signed [PW-1:0] r2_bxx, r2_byy, r2_cxx, r2_cyy, r2_bxcy, r2_bycx, r2_qxx, r2_qyy;
    // Stage 3: squared lengths and the doubled determinant.
    logic signed [W-1:0]   r3_ax, r3_ay;
    logic signed [DW-1:0]  r3_bx, r3_by, r3_cx, r3_cy, r3_qx, r3_qy;
    logic signed [SQW-1:0] r3_bb, r3_cc, r3_d, r3_qq;
    // Stage 4: partial products.
    logic signed [W-1:0]          r4_ax, r4_ay;
    logic signed [DW-1:0]         r4_qx, r4_qy;
    logic signed [SQW-1:0]        r4_d;
    logic                         r4_coll;
    logic signed [DW+CH:0]        r4_ybl, r4_ycl, r4_xcl, r4_xbl;
    logic signed [DW+SQW-CH-1:0]  r4_ybh, r4_ych, r4_xch, r4_xbh;
    logic signed [2*CH+1:0]       r4_ll;
    logic signed [SQW:0]          r4_lh, r4_hl;
    logic signed [2*(SQW-CH)-1:0] r4_hh;
    // Stage 5: partial product sums.
    logic signed [W-1:0]   r5_ax, r5_ay;
    logic signed [DW-1:0]  r5_qx, r5_qy;
    logic signed [SQW-1:0] r5_d;
    logic                  r5_coll;
    logic signed [NW-1:0]  r5_pbby, r5_pccy, r5_pccx, r5_pbbx;
    logic signed [EW-1:0]  r5_qa, r5_qb;
    // Stage 6: centre numerators and |q|^2 * D.
    logic signed [W-1:0]   r6_ax, r6_ay;
    logic signed [DW-1:0]  r6_qx, r6_qy;
    logic signed [SQW-1:0] r6_d;
    logic                  r6_coll;
    logic signed [NW-1:0]  r6_nx, r6_ny;
    logic signed [EW-1:0]  r6_qqd;
    // Stages 7 to 9: q . N in chunks.
    logic signed [W-1:0]    r7_ax, r7_ay, r8_ax, r8_ay, r9_ax, r9_ay;
    logic signed [SQW-1:0]  r7_d, r8_d, r9_d;
    logic                   r7_coll, r8_coll, r9_coll;
    logic signed [NW-1:0]   r7_nx, r7_ny, r8_nx, r8_ny, r9_nx, r9_ny;
    logic signed [EW-1:0]   r7_qqd, r8_qqd, r9_qqd;
    logic signed [DW+CH:0]  r7_xp0, r7_xp1, r7_yp0, r7_yp1;
    logic signed [DW+NW-2*CH-1:0] r7_xp2, r7_yp2, r8_xp2, r8_yp2;
    logic signed [EW-1:0]   r8_xs, r8_ys, r9_qnx, r9_qny;
    // Stage 10: magnitudes for the divider.
    logic signed [W-1:0]   r10_ax, r10_ay;
    logic signed [SQW-1:0] r10_d;
    logic                  r10_coll, r10_negx, r10_negy;
    logic [NW-1:0]         r10_anx, r10_any;
    logic [SQW-1:0]        r10_ad;
    logic signed [EW-1:0]  r10_qqd, r10_qn;
    // Stage 11: rounded dividends and the exact inside term.
    logic signed [W-1:0]   r11_ax, r11_ay;
    logic signed [SQW-1:0] r11_d;
    logic                  r11_coll, r11_negx, r11_negy;
    logic [RW-1:0]         r11_nnx, r11_nny;
    logic [SQW:0]          r11_dd;
    logic signed [EW-1:0]  r11_e;

    // Front datapath; payload registers without reset.
    always_ff @(posedge i_clk) begin
        r1_ax <= i_vertex_a_x;
        r1_ay <= i_vertex_a_y;
        r1_bx <= DW'(i_vertex_b_x) - DW'(i_vertex_a_x);
        r1_by <= DW'(i_vertex_b_y) - DW'(i_vertex_a_y);
        r1_cx <= DW'(i_vertex_c_x) - DW'(i_vertex_a_x);
        r1_cy <= DW'(i_vertex_c_y) - DW'(i_vertex_a_y);
        r1_qx <= DW'(i_query_x) - DW'(i_vertex_a_x);
        r1_qy <= DW'(i_query_y) - DW'(i_vertex_a_y);

        r2_ax <= r1_ax;  r2_ay <= r1_ay;
        r2_bx <= r1_bx;  r2_by <= r1_by;  r2_cx <= r1_cx;  r2_cy <= r1_cy;
        r2_qx <= r1_qx;  r2_qy <= r1_qy;
        r2_bxx  <= r1_bx * r1_bx;
        r2_byy  <= r1_by * r1_by;
        r2_cxx  <= r1_cx * r1_cx;
        r2_cyy  <= r1_cy * r1_cy;
        r2_bxcy <= r1_bx * r1_cy;
        r2_bycx <= r1_by * r1_cx;
        r2_qxx  <= r1_qx * r1_qx;
        r2_qyy  <= r1_qy * r1_qy;

        r3_ax <= r2_ax;  r3_ay <= r2_ay;
        r3_bx <= r2_bx;  r3_by <= r2_by;  r3_cx <= r2_cx;  r3_cy <= r2_cy;
        r3_qx <= r2_qx;  r3_qy <= r2_qy;
        r3_bb <= SQW'(r2_bxx) + SQW'(r2_byy);
        r3_cc <= SQW'(r2_cxx) + SQW'(r2_cyy);
        r3_qq <= SQW'(r2_qxx) + SQW'(r2_qyy);
        r3_d  <= (SQW'(r2_bxcy) - SQW'(r2_bycx)) <<< 1;

        // Split the 52-bit factors into an unsigned low chunk and a high chunk.
        r4_ax <= r3_ax;  r4_ay <= r3_ay;
        r4_qx <= r3_qx;  r4_qy <= r3_qy;
        r4_d  <= r3_d;
        r4_coll <= (r3_d == '0);
        r4_ybl <= r3_cy * $signed({1'b0, r3_bb[CH-1:0]});
        r4_ybh <= r3_cy * $signed(r3_bb[SQW-1:CH]);
        r4_ycl <= r3_by * $signed({1'b0, r3_cc[CH-1:0]});
        r4_ych <= r3_by * $signed(r3_cc[SQW-1:CH]);
        r4_xcl <= r3_bx * $signed({1'b0, r3_cc[CH-1:0]});
        r4_xch <= r3_bx * $signed(r3_cc[SQW-1:CH]);
        r4_xbl <= r3_cx * $signed({1'b0, r3_bb[CH-1:0]});
        r4_xbh <= r3_cx * $signed(r3_bb[SQW-1:CH]);
        r4_ll  <= $signed({1'b0, r3_qq[CH-1:0]}) * $signed({1'b0, r3_d[CH-1:0]});
        r4_lh  <= $signed({1'b0, r3_qq[CH-1:0]}) * $signed(r3_d[SQW-1:CH]);
        r4_hl  <= $signed(r3_qq[SQW-1:CH]) * $signed({1'b0, r3_d[CH-1:0]});
        r4_hh  <= $signed(r3_qq[SQW-1:CH]) * $signed(r3_d[SQW-1:CH]);

        r5_ax <= r4_ax;  r5_ay <= r4_ay;
        r5_qx <= r4_qx;  r5_qy <= r4_qy;
        r5_d  <= r4_d;   r5_coll <= r4_coll;
        r5_pbby <= NW'(r4_ybl) + (NW'(r4_ybh) <<< CH);
        r5_pccy <= NW'(r4_ycl) + (NW'(r4_ych) <<< CH);
        r5_pccx <= NW'(r4_xcl) + (NW'(r4_xch) <<< CH);
        r5_pbbx <= NW'(r4_xbl) + (NW'(r4_xbh) <<< CH);
        r5_qa   <= EW'(r4_ll) + (EW'(r4_lh) <<< CH);
        r5_qb   <= EW'(r4_hl) + (EW'(r4_hh) <<< CH);

        r6_ax <= r5_ax;  r6_ay <= r5_ay;
        r6_qx <= r5_qx;  r6_qy <= r5_qy;
        r6_d  <= r5_d;   r6_coll <= r5_coll;
        r6_nx  <= r5_pbby - r5_pccy;
        r6_ny  <= r5_pccx - r5_pbbx;
        r6_qqd <= r5_qa + (r5_qb <<< CH);

        r7_ax <= r6_ax;  r7_ay <= r6_ay;
        r7_d  <= r6_d;   r7_coll <= r6_coll;
        r7_nx <= r6_nx;  r7_ny <= r6_ny;  r7_qqd <= r6_qqd;
        r7_xp0 <= r6_qx * $signed({1'b0, r6_nx[CH-1:0]});
        r7_xp1 <= r6_qx * $signed({1'b0, r6_nx[2*CH-1:CH]});
        r7_xp2 <= r6_qx * $signed(r6_nx[NW-1:2*CH]);
        r7_yp0 <= r6_qy * $signed({1'b0, r6_ny[CH-1:0]});
        r7_yp1 <= r6_qy * $signed({1'b0, r6_ny[2*CH-1:CH]});
        r7_yp2 <= r6_qy * $signed(r6_ny[NW-1:2*CH]);

        r8_ax <= r7_ax;  r8_ay <= r7_ay;
        r8_d  <= r7_d;   r8_coll <= r7_coll;
        r8_nx <= r7_nx;  r8_ny <= r7_ny;  r8_qqd <= r7_qqd;
        r8_xs  <= EW'(r7_xp0) + (EW'(r7_xp1) <<< CH);
        r8_ys  <= EW'(r7_yp0) + (EW'(r7_yp1) <<< CH);
        r8_xp2 <= r7_xp2;
        r8_yp2 <= r7_yp2;

        r9_ax <= r8_ax;  r9_ay <= r8_ay;
        r9_d  <= r8_d;   r9_coll <= r8_coll;
        r9_nx <= r8_nx;  r9_ny <= r8_ny;  r9_qqd <= r8_qqd;
        r9_qnx <= r8_xs + (EW'(r8_xp2) <<< (2 * CH));
        r9_qny <= r8_ys + (EW'(r8_yp2) <<< (2 * CH));

        r10_ax <= r9_ax;  r10_ay <= r9_ay;
        r10_d  <= r9_d;   r10_coll <= r9_coll;
        r10_qqd <= r9_qqd;
        r10_qn  <= r9_qnx + r9_qny;
        r10_anx <= r9_nx[NW-1] ? NW'(-r9_nx) : NW'(r9_nx);
        r10_any <= r9_ny[NW-1] ? NW'(-r9_ny) : NW'(r9_ny);
        r10_ad  <= r9_d[SQW-1] ? SQW'(-r9_d) : SQW'(r9_d);
        r10_negx <= (r9_nx[NW-1] != r9_d[SQW-1]);
        r10_negy <= (r9_ny[NW-1] != r9_d[SQW-1]);

        // Rounded division: (2|n| + |d|) / (2|d|).
        r11_ax <= r10_ax;  r11_ay <= r10_ay;
        r11_d  <= r10_d;   r11_coll <= r10_coll;
        r11_negx <= r10_negx;
        r11_negy <= r10_negy;
        r11_nnx <= RW'({r10_anx, 1'b0}) + RW'(r10_ad);
        r11_nny <= RW'({r10_any, 1'b0}) + RW'(r10_ad);
        r11_dd  <= {r10_ad, 1'b0};
        r11_e   <= r10_qqd - (r10_qn <<< 1);
    end

    // Divider entry: overflow check of the quotient and the inside decision.
    t_div_beat r_div_in;
    t_div_beat w_div [0:QB];

    always_ff @(posedge i_clk) begin
        r_div_in.rem_x <= r11_nnx;
        r_div_in.rem_y <= r11_nny;
        r_div_in.dv    <= RW'(r11_dd) << (QB - 1);
        r_div_in.q_x   <= '0;
        r_div_in.q_y   <= '0;
        r_div_in.side.ax    <= r11_ax;
        r_div_in.side.ay    <= r11_ay;
        r_div_in.side.neg_x <= r11_negx;
        r_div_in.side.neg_y <= r11_negy;
        r_div_in.side.big_x <= (r11_nnx >= (RW'(r11_dd) << QB));
        r_div_in.side.big_y <= (r11_nny >= (RW'(r11_dd) << QB));
        r_div_in.side.in_circle <= (r11_e != '0) && (r11_e[EW-1] != r11_d[SQW-1]);
        r_div_in.side.coll      <= r11_coll;
        if (!i_rst_n) begin
            r_div_in.vld <= 1'b0;
        end else begin
            r_div_in.vld <= r_vld[10];
        end
    end

    assign w_div[0] = r_div_in;

    // Chain of divider cells, one quotient bit per cell.
    for (genvar k = 0; k < QB; k++) begin : g_div
        tcc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_div[k]),
            .o_beat  (w_div[k+1])
        );
    end

    // Centre clamp: a quotient past the divider range always saturates.
    function automatic logic [W:0] clamp_coord(input logic signed [VW-1:0] v,
                                               input logic big, input logic neg);
        logic [W:0] r;
        if (big) begin
            r = neg ? {1'b1, CEN_MIN[W-1:0]} : {1'b1, CEN_MAX[W-1:0]};
        end else if (v > CEN_MAX) begin
            r = {1'b1, CEN_MAX[W-1:0]};
        end else if (v < CEN_MIN) begin
            r = {1'b1, CEN_MIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    t_div_beat            w_db;
    logic signed [VW-1:0] w_vx, w_vy;
    logic [W:0]           w_cx, w_cy;

    assign w_db = w_div[QB];
    assign w_vx = VW'($signed(w_db.side.ax)) + (w_db.side.neg_x ?
                  -$signed(VW'(w_db.q_x)) : $signed(VW'(w_db.q_x)));
    assign w_vy = VW'($signed(w_db.side.ay)) + (w_db.side.neg_y ?
                  -$signed(VW'(w_db.q_y)) : $signed(VW'(w_db.q_y)));
    assign w_cx = clamp_coord(w_vx, w_db.side.big_x, w_db.side.neg_x);
    assign w_cy = clamp_coord(w_vy, w_db.side.big_y, w_db.side.neg_y);

    // Radius stages: clamp, square, sum.
    logic           r_p1_vld, r_p2_vld;
    t_sqrt_side     r_p1_side, r_p2_side;
    logic [W-1:0]   r_p1_ux, r_p1_uy;
    logic [SRW-1:0] r_p2_sx, r_p2_sy;
    t_sqrt_beat     r_sq_in;
    t_sqrt_beat     w_sq [0:W];
    logic [SRW:0]   w_r2;

    assign w_r2 = (SRW + 1)'(r_p2_sx) + (SRW + 1)'(r_p2_sy);

    always_ff @(posedge i_clk) begin
        r_p1_side.cen_x     <= w_cx[W-1:0];
        r_p1_side.cen_y     <= w_cy[W-1:0];
        r_p1_side.in_circle <= w_db.side.in_circle;
        r_p1_side.coll      <= w_db.side.coll;
        r_p1_side.sat       <= w_cx[W] | w_cy[W];
        r_p1_side.rsat      <= w_db.side.big_x | w_db.side.big_y |
                               (|w_db.q_x[QB-1:W]) | (|w_db.q_y[QB-1:W]);
        r_p1_ux <= w_db.q_x[W-1:0];
        r_p1_uy <= w_db.q_y[W-1:0];

        r_p2_side <= r_p1_side;
        r_p2_sx   <= r_p1_ux * r_p1_ux;
        r_p2_sy   <= r_p1_uy * r_p1_uy;

        r_sq_in.x    <= w_r2[SRW-1:0];
        r_sq_in.res  <= '0;
        r_sq_in.pos  <= (SRW + 1)'(1) << (SRW - 2);
        r_sq_in.side.cen_x     <= r_p2_side.cen_x;
        r_sq_in.side.cen_y     <= r_p2_side.cen_y;
        r_sq_in.side.in_circle <= r_p2_side.in_circle;
        r_sq_in.side.coll      <= r_p2_side.coll;
        r_sq_in.side.sat       <= r_p2_side.sat;
        r_sq_in.side.rsat      <= r_p2_side.rsat | w_r2[SRW];

        if (!i_rst_n) begin
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_sq_in.vld <= 1'b0;
        end else begin
            r_p1_vld    <= w_db.vld;
            r_p2_vld    <= r_p1_vld;
            r_sq_in.vld <= r_p2_vld;
        end
    end

    assign w_sq[0] = r_sq_in;

    // Chain of square root cells, one result bit per cell.
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        tcc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_sq[k]),
            .o_beat  (w_sq[k+1])
        );
    end

    // Round the root to nearest and assemble the result beat.
    t_sqrt_beat   w_sb;
    logic [W:0]   w_rad;
    logic         w_rsat;

    assign w_sb   = w_sq[W];
    assign w_rad  = w_sb.res[W:0] + (W + 1)'({1'b0, w_sb.x} > w_sb.res);
    assign w_rsat = w_sb.side.rsat | w_rad[W];

    logic         r_done;
    logic [W-1:0] r_centre_x, r_centre_y, r_radius;
    logic         r_inside;
    logic [1:0]   r_status;

    always_ff @(posedge i_clk) begin
        if (w_sb.side.coll) begin
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_radius   <= '0;
            r_inside   <= 1'b0;
            r_status   <= ST_COLL;
        end else begin
            r_centre_x <= w_sb.side.cen_x;
            r_centre_y <= w_sb.side.cen_y;
            r_radius   <= w_rsat ? {W{1'b1}} : w_rad[W-1:0];
            r_inside   <= w_sb.side.in_circle;
            r_status   <= (w_sb.side.sat | w_rsat) ? ST_SAT : ST_OK;
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_sb.vld;
        end
    end

    assign o_done          = r_done;
    assign o_centre_x      = $signed(r_centre_x);
    assign o_centre_y      = $signed(r_centre_y);
    assign o_circle_radius = r_radius;
    assign o_point_inside  = r_inside;
    assign o_result_status = r_status;

endmodule

`default_nettype wire

// ----- bench/tb_triangle_circumcircle_point_test.sv -----
`timescale 1ns / 1ps

module tb_triangle_circumcircle_point_test;
    import tcc_pkg::*;

    localparam int CW        = tcc_pkg::COORD_WIDTH;
    localparam int WIDE      = 160;
    localparam int LATENCY   = 66;
    localparam int CYCLE_MAX = 400000;

    typedef logic signed [WIDE-1:0] t_wide;
    typedef logic signed [CW-1:0]   t_coord;

    // One expected circumcircle result.
    typedef struct {
        t_coord          cen_x;
        t_coord          cen_y;
        logic [CW-1:0]   radius;
        logic            in_circle;
        logic [1:0]      status;
    } t_circle;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y;
    t_coord i_vertex_c_x, i_vertex_c_y, i_query_x, i_query_y;
    logic   o_done;
    t_coord o_centre_x, o_centre_y;
    logic [CW-1:0] o_circle_radius;
    logic   o_point_inside;
    logic [1:0] o_result_status;

    t_circle circle_queue[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      burst_mode;

    triangle_circumcircle_point_test u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_vertex_a_x    (i_vertex_a_x),
        .i_vertex_a_y    (i_vertex_a_y),
        .i_vertex_b_x    (i_vertex_b_x),
        .i_vertex_b_y    (i_vertex_b_y),
        .i_vertex_c_x    (i_vertex_c_x),
        .i_vertex_c_y    (i_vertex_c_y),
        .i_query_x       (i_query_x),
        .i_query_y       (i_query_y),
        .o_done          (o_done),
        .o_centre_x      (o_centre_x),
        .o_centre_y      (o_centre_y),
        .o_circle_radius (o_circle_radius),
        .o_point_inside  (o_point_inside),
        .o_result_status (o_result_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Quotient rounded to nearest, ties away from zero.
    function automatic t_wide div_round(input t_wide num, input t_wide den);
        t_wide an;
        t_wide ad;
        t_wide q;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q  = (2 * an + ad) / (2 * ad);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Square root rounded to nearest.
    function automatic logic [63:0] sqrt_round(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= x) root = trial;
        end
        if (x - root * root > root) root = root + 1;
        return root;
    endfunction

    // Clamp a centre coordinate to the signed coordinate range.
    function automatic t_coord clamp_coord(input t_wide v, inout logic sat);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        lo = -(t_wide'(1) <<< (CW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return t_coord'(hi);
        end
        if (v < lo) begin
            sat = 1'b1;
            return t_coord'(lo);
        end
        return t_coord'(v);
    endfunction

    // Circumcircle of A, B, C and strict inside test of Q, all relative to A.
    function automatic t_circle predict_circle(input t_coord ax, input t_coord ay,
                                               input t_coord bx, input t_coord by,
                                               input t_coord cx, input t_coord cy,
                                               input t_coord qx, input t_coord qy);
        t_circle r;
        t_wide   dbx, dby, dcx, dcy, dqx, dqy;
        t_wide   bb, cc, det, nx, ny, e, ux, uy, r2, lim;
        logic    sat;
        dbx = t_wide'(bx) - t_wide'(ax);
        dby = t_wide'(by) - t_wide'(ay);
        dcx = t_wide'(cx) - t_wide'(ax);
        dcy = t_wide'(cy) - t_wide'(ay);
        dqx = t_wide'(qx) - t_wide'(ax);
        dqy = t_wide'(qy) - t_wide'(ay);
        bb  = dbx * dbx + dby * dby;
        cc  = dcx * dcx + dcy * dcy;
        det = 2 * (dbx * dcy - dby * dcx);
        r   = '{cen_x: '0, cen_y: '0, radius: '0, in_circle: 1'b0, status: ST_OK};
        if (det == 0) begin
            r.status = ST_COLL;
            return r;
        end
        nx = dcy * bb - dby * cc;
        ny = dbx * cc - dcx * bb;
        e  = (dqx * dqx + dqy * dqy) * det - 2 * (dqx * nx + dqy * ny);
        r.in_circle = (e != 0) && ((e < 0) != (det < 0));
        ux  = div_round(nx, det);
        uy  = div_round(ny, det);
        sat = 1'b0;
        r.cen_x = clamp_coord(t_wide'(ax) + ux, sat);
        r.cen_y = clamp_coord(t_wide'(ay) + uy, sat);
        lim = t_wide'(1) <<< CW;
        r2  = ux * ux + uy * uy;
        if (ux >= lim || -ux >= lim || uy >= lim || -uy >= lim
                || r2 >= (t_wide'(1) <<< (2 * CW))) begin
            r.radius = '1;
            sat = 1'b1;
        end else begin
            r2 = sqrt_round(64'(r2));
            if (r2 >= lim) begin
                r.radius = '1;
                sat = 1'b1;
            end else begin
                r.radius = r2[CW-1:0];
            end
        end
        if (sat) r.status = ST_SAT;
        return r;
    endfunction

    // Send one beat and record its expected result once accepted.
    task automatic send_triangle(input t_coord ax, input t_coord ay,
                                 input t_coord bx, input t_coord by,
                                 input t_coord cx, input t_coord cy,
                                 input t_coord qx, input t_coord qy);
        int gap;
        start        <= 1'b1;
        i_vertex_a_x <= ax;
        i_vertex_a_y <= ay;
        i_vertex_b_x <= bx;
        i_vertex_b_y <= by;
        i_vertex_c_x <= cx;
        i_vertex_c_y <= cy;
        i_query_x    <= qx;
        i_query_y    <= qy;
        do @(posedge i_clk); while (busy);
        circle_queue.push_back(predict_circle(ax, ay, bx, by, cx, cy, qx, qy));
        // Mostly back to back, sometimes a short pause, rarely a long one.
        gap = 0;
        if (!burst_mode) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7, 8:    gap = $urandom_range(1, 3);
                default:       gap = $urandom_range(8, 40);
            endcase
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_coord rand_coord(input int bits);
        logic [31:0] raw;
        raw = $urandom();
        if (bits >= CW) return t_coord'(raw);
        return t_coord'($signed(raw) >>> (32 - bits));
    endfunction

    // Corners of the coordinate range, zero and degenerate vertices.
    task automatic test_extremes();
        t_coord mx;
        t_coord mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0);
        send_triangle(mn, mn, mx, mn, mn, mx, 0, 0);
        send_triangle(mx, mx, mn, mx, mx, mn, mn, mn);
        send_triangle(mn, mn, mx, mx, mn, mx, mx, mn);
        send_triangle(mx, mn, mn, mx, mx, mx, -1, -1);
        send_triangle(5, 5, 5, 5, 700, 9, 1, 1);
        send_triangle(mn, 0, mx, 0, 0, mx, mx, mx);
    endtask

    // Collinear vertices give the collinear status with zero fields.
    task automatic test_collinear();
        send_triangle(0, 0, 256, 256, 512, 512, 10, 0);
        send_triangle(-300, 100, 100, 100, 900, 100, 0, 0);
        send_triangle(77, -5000, 77, 20, 77, 9000, 77, 0);
        send_triangle(1234, 4321, 1234, 4321, 1234, 4321, 0, 0);
    endtask

    // Query inside, outside and exactly on the circle.
    task automatic test_inside();
        send_triangle(-256, 0, 256, 0, 0, 256, 0, 0);
        send_triangle(-256, 0, 256, 0, 0, 256, 0, 256);
        send_triangle(-256, 0, 256, 0, 0, 256, 0, -256);
        send_triangle(-256, 0, 256, 0, 0, 256, 0, -255);
        send_triangle(-256, 0, 256, 0, 0, 256, 300, 300);
        send_triangle(0, 0, 3, 0, 0, 3, 1, 1);
        send_triangle(0, 0, 3, 0, 0, 3, 2, 1);
    endtask

    // Triangles near the saturation limits; the nearly collinear ones push the centre and radius out of range.
    task automatic test_saturation();
        send_triangle(0, 0, 4000000, 0, 8000000, 1, 0, 0);
        send_triangle(0, 0, -4000000, 0, -8000000, -1, 1, 1);
        send_triangle(-8000000, 0, 0, 1, 8000000, 0, 0, 100);
        send_triangle(0, 0, 1, 0, 2, 1, 0, 0);
        send_triangle(8000000, 8000000, 8388607, 8000000, 8000000, 8388607, 0, 0);
    endtask

    // Random triangles at mixed scales, some collinear or nearly so, with on-vertex and central queries.
    task automatic test_random(input int count);
        t_coord ax, ay, bx, by, cx, cy, qx, qy;
        int     bits;
        int     k;
        for (int n = 0; n < count; n++) begin
            burst_mode = (n % 200) < 40;
            case ($urandom_range(0, 3))
                0:       bits = CW;
                1:       bits = $urandom_range(4, 12);
                default: bits = $urandom_range(12, CW - 1);
            endcase
            ax = rand_coord(bits);
            ay = rand_coord(bits);
            bx = rand_coord(bits);
            by = rand_coord(bits);
            cx = rand_coord(bits);
            cy = rand_coord(bits);
            qx = rand_coord(bits);
            qy = rand_coord(bits);
            case ($urandom_range(0, 9))
                0: begin
                    // C on the line through A and B.
                    k  = $urandom_range(0, 6) - 3;
                    cx = t_coord'(ax + k * (bx - ax));
                    cy = t_coord'(ay + k * (by - ay));
                end
                1: begin
                    qx = bx;
                    qy = by;
                end
                2: begin
                    // Query near the middle of the triangle.
                    qx = t_coord'((ax + bx + cx) / 3 + $signed($urandom_range(0, 4)) - 2);
                    qy = t_coord'((ay + by + cy) / 3 + $signed($urandom_range(0, 4)) - 2);
                end
                3: begin
                    // Nearly collinear: C one step off the line.
                    cx = t_coord'(ax + 2 * (bx - ax));
                    cy = t_coord'(ay + 2 * (by - ay) + 1);
                end
                default: ;
            endcase
            send_triangle(ax, ay, bx, by, cx, cy, qx, qy);
        end
        burst_mode = 1'b0;
    endtask

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_circle exp_c;
        if (i_rst_n && o_done) begin
            if (circle_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat at cycle %0d", cycle_count);
            end else begin
                exp_c = circle_queue.pop_front();
                if (o_centre_x !== exp_c.cen_x || o_centre_y !== exp_c.cen_y
                        || o_circle_radius !== exp_c.radius
                        || o_point_inside !== exp_c.in_circle
                        || o_result_status !== exp_c.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected cx=%0d cy=%0d r=%0d in=%0b st=%0d, ",
                                  "got cx=%0d cy=%0d r=%0d in=%0b st=%0d"},
                                 exp_c.cen_x, exp_c.cen_y, exp_c.radius, exp_c.in_circle,
                                 exp_c.status, o_centre_x, o_centre_y, o_circle_radius,
                                 o_point_inside, o_result_status);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        burst_mode     = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_vertex_a_x   = '0;
        i_vertex_a_y   = '0;
        i_vertex_b_x   = '0;
        i_vertex_b_y   = '0;
        i_vertex_c_x   = '0;
        i_vertex_c_y   = '0;
        i_query_x      = '0;
        i_query_y      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_collinear();
        test_inside();
        test_saturation();
        test_random(680);

        start <= 1'b0;
        while (circle_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tcc_pkg.sv
hdl/tcc_div_cell.sv
hdl/tcc_sqrt_cell.sv
hdl/triangle_circumcircle_point_test.sv
bench/tb_triangle_circumcircle_point_test.sv
